>>> rtl/olir_pkg.sv
// ----------------------------------------------------------------------------
// olir_pkg: shared types and codes for the ordered list core
// Command and status codes and the result beat passed to the output stage.
// ----------------------------------------------------------------------------
package olir_pkg;

    localparam int CmdW    = 4;
    localparam int StatusW = 3;
    localparam int ValueW  = 32;
    localparam int PosW    = 5;
    localparam int IndexW  = 4;
    localparam int CountW  = 5;

    localparam logic [CmdW-1:0] CMD_INS_AT     = 4'd0;
    localparam logic [CmdW-1:0] CMD_INS_FRONT  = 4'd1;
    localparam logic [CmdW-1:0] CMD_INS_BACK   = 4'd2;
    localparam logic [CmdW-1:0] CMD_REM_AT     = 4'd3;
    localparam logic [CmdW-1:0] CMD_REM_FRONT  = 4'd4;
    localparam logic [CmdW-1:0] CMD_REM_BACK   = 4'd5;
    localparam logic [CmdW-1:0] CMD_DUMP_FWD   = 4'd6;
    localparam logic [CmdW-1:0] CMD_DUMP_REV   = 4'd7;
    localparam logic [CmdW-1:0] CMD_FIND       = 4'd8;

    localparam logic [StatusW-1:0] STS_OK      = 3'd0;
    localparam logic [StatusW-1:0] STS_BADPOS  = 3'd1;
    localparam logic [StatusW-1:0] STS_EMPTY   = 3'd2;
    localparam logic [StatusW-1:0] STS_FULL    = 3'd3;
    localparam logic [StatusW-1:0] STS_NOMATCH = 3'd4;

    typedef struct packed {
        logic                     last;
        logic [CountW-1:0]        count;
        logic [IndexW-1:0]        index;
        logic signed [ValueW-1:0] value;
        logic [StatusW-1:0]       status;
    } beat_t;

endpackage

>>> rtl/ordered_list_insert_remove_core.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_core: bounded ordered list of signed values
// Insert and remove at a position or either end, dump in either direction,
// and search for a value, reporting every matching index.
//
//   channel  dir  tdata fields (lsb first)                 tlast
//   s_       in   cmd, value, position                     -
//   m_       out  status, value_res, index, count          last_of_run
//
// End insert, end removal, error and spare codes respond from the decode; other
// inserts and removes shift entries first, and dump and find walk them, as the
// single read port reads one entry a cycle while the m_ side does not stall.
// aresetn (synchronous) empties the list; storage itself is not cleared.
// A stalled m_ side holds the sequencer, and s_tready stays low until the
// command has handed its last beat to the output register.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_core #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // cmd[3:0], value[35:4], position[40:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // status[2:0], value_res[34:3], index[38:35], count[43:39]
    output logic        m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                 out_free;
    logic                 push;
    olir_pkg::beat_t      beat;
    logic                 m_tvalid_reg;
    logic [47:0]          m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_waddr, mem_raddr;
    logic [31:0]          mem_wdata, mem_rdata;

    assign out_free = !m_tvalid_reg || m_tready;

    olir_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[3:0]),
        .in_value  (s_tdata[35:4]),
        .in_pos    (s_tdata[40:36]),
        .out_free  (out_free),
        .push      (push),
        .beat      (beat),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    olir_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: load a beat when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= push;
        end
        if (push) begin
            m_tdata_reg <= {4'b0, beat.count, beat.index, beat.value, beat.status};
            m_tlast_reg <= beat.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/olir_mem.sv
// ----------------------------------------------------------------------------
// olir_mem: list storage
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module olir_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/olir_ctrl.sv
// ----------------------------------------------------------------------------
// olir_ctrl: command sequencer
// Decodes a command, then walks the storage one entry a cycle (a dump or find
// walk holds while the output stage is full) with a shared step/compare unit:
// shifting entries for insert and remove, reading them out for dump and find.
// ----------------------------------------------------------------------------
module olir_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [olir_pkg::CmdW-1:0]      in_cmd,
    input  logic [olir_pkg::ValueW-1:0]    in_value,
    input  logic [olir_pkg::PosW-1:0]      in_pos,
    input  logic                           out_free,
    output logic                           push,
    output olir_pkg::beat_t                beat,
    output logic                           mem_we,
    output logic [IW-1:0]                  mem_waddr,
    output logic [31:0]                    mem_wdata,
    output logic                           mem_re,
    output logic [IW-1:0]                  mem_raddr,
    input  logic [31:0]                    mem_rdata
);

    localparam int WW = (CW > olir_pkg::PosW) ? CW : olir_pkg::PosW;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_PUT   = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_FLUSH = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [IW-1:0]                   pos_reg, pos_next;
    logic [31:0]                     val_reg, val_next;
    logic                            dec_reg, dec_next;
    logic                            find_reg, find_next;
    logic                            pend_reg, pend_next;
    logic [IW-1:0]                   pend_idx_reg, pend_idx_next;
    logic [olir_pkg::StatusW-1:0]    res_status_reg, res_status_next;
    logic [IW-1:0]                   res_idx_reg, res_idx_next;

    logic [WW-1:0]                   cnt_w, pos_w, p_w, cnt_m1_w;
    logic [IW-1:0]                   cnt_m1;
    logic [IW:0]                     step1, step2;
    logic [IW-1:0]                   nxt, nxt2, lim;
    logic                            stop_shift, scan_done, match;
    logic [IW-1:0]                   beat_idx;

    assign in_ready = (state_reg == ST_IDLE);
    assign cnt_w    = WW'(count_reg);
    assign pos_w    = WW'(in_pos);
    assign cnt_m1_w = cnt_w - WW'(1);
    assign cnt_m1   = cnt_m1_w[IW-1:0];

    // shared walk unit: step the index by one or two and compare to the limit
    assign step1      = dec_reg ? ({1'b0, idx_reg} - (IW+1)'(1)) : ({1'b0, idx_reg} + (IW+1)'(1));
    assign step2      = dec_reg ? ({1'b0, idx_reg} - (IW+1)'(2)) : ({1'b0, idx_reg} + (IW+1)'(2));
    assign nxt        = step1[IW-1:0];
    assign nxt2       = step2[IW-1:0];
    assign lim        = (state_reg == ST_SHIFT) ? (dec_reg ? pos_reg : cnt_m1)
                                                : (dec_reg ? '0 : cnt_m1);
    assign stop_shift = (nxt == lim);
    assign scan_done  = (idx_reg == lim);
    assign match      = (mem_rdata == val_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        dec_next        = dec_reg;
        find_next       = find_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        p_w             = pos_w;
        push            = 1'b0;
        beat.status     = olir_pkg::STS_OK;
        beat.value      = '0;
        beat.last       = 1'b1;
        beat.count      = olir_pkg::CountW'(count_reg);
        beat_idx        = res_idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = nxt;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    res_idx_next    = '0;
                    res_status_next = olir_pkg::STS_OK;
                    state_next      = ST_RESP;
                    val_next        = in_value;
                    if (in_cmd == olir_pkg::CMD_INS_AT || in_cmd == olir_pkg::CMD_INS_FRONT ||
                        in_cmd == olir_pkg::CMD_INS_BACK) begin
                        if (in_cmd == olir_pkg::CMD_INS_FRONT) begin
                            p_w = '0;
                        end else if (in_cmd == olir_pkg::CMD_INS_BACK) begin
                            p_w = cnt_w;
                        end
                        if (p_w > cnt_w) begin
                            res_status_next = olir_pkg::STS_BADPOS;
                        end else if (cnt_w >= WW'(CAPACITY)) begin
                            res_status_next = olir_pkg::STS_FULL;
                        end else if (p_w == cnt_w) begin
                            mem_we       = 1'b1;
                            mem_waddr    = p_w[IW-1:0];
                            mem_wdata    = in_value;
                            count_next   = count_reg + CW'(1);
                            res_idx_next = p_w[IW-1:0];
                        end else begin
                            // open a gap: move entries up from the tail
                            mem_re     = 1'b1;
                            mem_raddr  = cnt_m1;
                            idx_next   = count_reg[IW-1:0];
                            pos_next   = p_w[IW-1:0];
                            dec_next   = 1'b1;
                            state_next = ST_SHIFT;
                        end
                    end else if (in_cmd == olir_pkg::CMD_REM_AT ||
                                 in_cmd == olir_pkg::CMD_REM_FRONT ||
                                 in_cmd == olir_pkg::CMD_REM_BACK) begin
                        if (in_cmd == olir_pkg::CMD_REM_FRONT) begin
                            p_w = '0;
                        end else if (in_cmd == olir_pkg::CMD_REM_BACK) begin
                            p_w = cnt_m1_w;
                        end
                        if (count_reg == '0) begin
                            res_status_next = olir_pkg::STS_EMPTY;
                        end else if (p_w >= cnt_w) begin
                            res_status_next = olir_pkg::STS_BADPOS;
                        end else if (p_w == cnt_m1_w) begin
                            count_next   = count_reg - CW'(1);
                            res_idx_next = p_w[IW-1:0];
                        end else begin
                            // close the gap: move entries down toward it
                            mem_re     = 1'b1;
                            mem_raddr  = p_w[IW-1:0] + IW'(1);
                            idx_next   = p_w[IW-1:0];
                            pos_next   = p_w[IW-1:0];
                            dec_next   = 1'b0;
                            state_next = ST_SHIFT;
                        end
                    end else if (in_cmd == olir_pkg::CMD_DUMP_FWD ||
                                 in_cmd == olir_pkg::CMD_DUMP_REV ||
                                 in_cmd == olir_pkg::CMD_FIND) begin
                        if (count_reg == '0) begin
                            res_status_next = olir_pkg::STS_EMPTY;
                        end else begin
                            dec_next   = (in_cmd == olir_pkg::CMD_DUMP_REV);
                            find_next  = (in_cmd == olir_pkg::CMD_FIND);
                            pend_next  = 1'b0;
                            mem_re     = 1'b1;
                            mem_raddr  = (in_cmd == olir_pkg::CMD_DUMP_REV) ? cnt_m1 : '0;
                            idx_next   = (in_cmd == olir_pkg::CMD_DUMP_REV) ? cnt_m1 : '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (!stop_shift) begin
                    mem_re    = 1'b1;
                    mem_raddr = nxt2;
                    idx_next  = nxt;
                end else if (dec_reg) begin
                    state_next = ST_PUT;
                end else begin
                    count_next   = count_reg - CW'(1);
                    res_idx_next = pos_reg;
                    state_next   = ST_RESP;
                end
            end
            ST_PUT: begin
                mem_we       = 1'b1;
                mem_waddr    = pos_reg;
                mem_wdata    = val_reg;
                count_next   = count_reg + CW'(1);
                res_idx_next = pos_reg;
                state_next   = ST_RESP;
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (!find_reg) begin
                        push       = 1'b1;
                        beat.value = mem_rdata;
                        beat_idx   = idx_reg;
                        beat.last  = scan_done;
                    end else if (match) begin
                        // hold the newest match back until the run end is known
                        push          = pend_reg;
                        beat.value    = val_reg;
                        beat_idx      = pend_idx_reg;
                        beat.last     = 1'b0;
                        pend_next     = 1'b1;
                        pend_idx_next = idx_reg;
                    end
                    if (scan_done) begin
                        state_next = find_reg ? ST_FLUSH : ST_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = nxt;
                        idx_next  = nxt;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    push        = 1'b1;
                    beat.status = pend_reg ? olir_pkg::STS_OK : olir_pkg::STS_NOMATCH;
                    beat.value  = pend_reg ? val_reg : '0;
                    beat_idx    = pend_reg ? pend_idx_reg : '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    push        = 1'b1;
                    beat.status = res_status_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        beat.index = olir_pkg::IndexW'(beat_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        dec_reg        <= dec_next;
        find_reg       <= find_next;
        pend_reg       <= pend_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("result pushed into a full output stage");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !push)
        else $error("result pushed while idle");

    a_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write to the same entry in one cycle");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_SHIFT && state_reg != ST_PUT)
            |=> $stable(count_reg))
        else $error("count changed outside insert or remove");
`endif

endmodule
